// File: src/eisc_pkg.sv
package eisc_pkg;

    // Pin count and the mask of pins that exist (at most eight).
    localparam int NUM_PINS  = 8;
    localparam int PIN_COUNT = (NUM_PINS > 8) ? 8 : NUM_PINS;
    localparam logic [7:0] PIN_MASK = 8'((16'h1 << PIN_COUNT) - 16'h1);

    // Request types
    localparam logic [1:0] REQ_SAMPLE = 2'd0;
    localparam logic [1:0] REQ_READ   = 2'd1;
    localparam logic [1:0] REQ_WRITE  = 2'd2;

    // Register select
    localparam logic REG_SEL_NMI = 1'b0;
    localparam logic REG_SEL_IRQ = 1'b1;

    // Configuration register indexes
    localparam logic CFG_IRQ_SENSE = 1'b0;
    localparam logic CFG_NMI_SENSE = 1'b1;

    // IRQ sense modes
    localparam logic [1:0] SENSE_LOW     = 2'd0;
    localparam logic [1:0] SENSE_FALLING = 2'd1;
    localparam logic [1:0] SENSE_RISING  = 2'd2;
    localparam logic [1:0] SENSE_BOTH    = 2'd3;

    // NMI sense modes
    localparam logic NMI_SENSE_FALLING = 1'b0;

    localparam logic [15:0] IRQ_SENSE_RESET = 16'hffff;

    typedef struct packed {
        logic [1:0] req_type;
        logic       reg_sel;
        logic [7:0] write_data;
        logic [7:0] irq_pin_levels;
        logic       nmi_pin_level;
    } eisc_in_t;

    typedef struct packed {
        logic [16:0] read_data;
        logic [7:0]  irq_pending;
        logic        nmi_pending;
    } eisc_out_t;

    // Events detected in one step
    typedef struct packed {
        logic [7:0] irq_event;
        logic       nmi_event;
    } eisc_event_t;

endpackage

// File: src/eisc_detect.sv
module eisc_detect
    import eisc_pkg::*;
(
    input  logic [15:0]  irq_sense_modes,
    input  logic         nmi_sense_mode,
    input  logic         sample_primed,
    input  logic [7:0]   prev_irq_levels,
    input  logic         prev_nmi_level,
    input  logic [7:0]   irq_levels,
    input  logic         nmi_level,
    output eisc_event_t  events
);

    logic [7:0] fall;
    logic [7:0] rise;
    logic [7:0] hit;

    assign fall = prev_irq_levels & ~irq_levels;
    assign rise = ~prev_irq_levels & irq_levels;

    always_comb begin
        for (int p = 0; p < 8; p++) begin
            unique case (irq_sense_modes[2*p +: 2])
                SENSE_LOW:     hit[p] = ~irq_levels[p];
                SENSE_FALLING: hit[p] = sample_primed & fall[p];
                SENSE_RISING:  hit[p] = sample_primed & rise[p];
                SENSE_BOTH:    hit[p] = sample_primed & (fall[p] | rise[p]);
                default:       hit[p] = 1'b0;
            endcase
        end
    end

    always_comb begin
        events.irq_event = hit & PIN_MASK;
        if (!sample_primed) begin
            events.nmi_event = 1'b0;
        end else if (nmi_sense_mode == NMI_SENSE_FALLING) begin
            events.nmi_event = prev_nmi_level & ~nmi_level;
        end else begin
            events.nmi_event = ~prev_nmi_level & nmi_level;
        end
    end

endmodule

// File: src/external_interrupt_sense_controller_core.sv
// External interrupt sense controller.
//
// Input channel (s_valid/s_ready/s_data): one transaction per sample of the
// eight IRQ pins and the NMI pin, optionally carrying a bus read or write of
// the IRQ or NMI status register. Each transaction yields exactly one result
// transaction on the output channel (m_valid/m_ready/m_data) with the read
// data and the pending request lines after that sample.
// Configuration (cfg_we/cfg_index/cfg_wdata) sets the per-pin sense modes;
// write it only while no transaction is in flight.
//
// The path from acceptance to result has one input register and one result
// register, with the edge detection and status update in between.
// Throughput is one transaction per cycle while the receiver accepts results;
// the status update loop through the status registers sets that figure.
// When the receiver stalls, the result register holds and the input register
// fills; s_ready drops only once both are occupied.
// Reset clears the status, the recorded pin levels and the primed flag, so
// the first sample after reset records levels without detecting edges, and
// restores the sense modes to both-edges for IRQ and falling for NMI.
module external_interrupt_sense_controller_core
    import eisc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  eisc_in_t    s_data,

    output logic        m_valid,
    input  logic        m_ready,
    output eisc_out_t   m_data,

    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata
);

    // Configuration
    logic [15:0] irq_sense_modes_reg;
    logic        nmi_sense_mode_reg;

    // Sense state
    logic [7:0]  irq_status_reg, irq_status_next;
    logic        nmi_status_reg, nmi_status_next;
    logic [7:0]  prev_irq_levels_reg;
    logic        prev_nmi_level_reg;
    logic        sample_primed_reg;

    // Pipeline registers
    logic        in_valid_reg;
    eisc_in_t    in_data_reg;
    logic        out_valid_reg;
    eisc_out_t   out_data_reg, out_data_next;

    logic        advance;
    eisc_event_t events;
    logic [7:0]  irq_kept;
    logic        nmi_kept;

    // Advance the input register into the result register whenever the
    // result slot is free or being drained this cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    eisc_detect u_detect (
        .irq_sense_modes (irq_sense_modes_reg),
        .nmi_sense_mode  (nmi_sense_mode_reg),
        .sample_primed   (sample_primed_reg),
        .prev_irq_levels (prev_irq_levels_reg),
        .prev_nmi_level  (prev_nmi_level_reg),
        .irq_levels      (in_data_reg.irq_pin_levels),
        .nmi_level       (in_data_reg.nmi_pin_level),
        .events          (events)
    );

    // Status update: a bus write clears zero bits first, then new events set
    // bits, so an event in the same step wins over the clear.
    always_comb begin
        irq_kept = irq_status_reg;
        nmi_kept = nmi_status_reg;
        if (in_data_reg.req_type == REQ_WRITE) begin
            if (in_data_reg.reg_sel == REG_SEL_IRQ) begin
                irq_kept = irq_status_reg & in_data_reg.write_data;
            end else begin
                nmi_kept = nmi_status_reg & in_data_reg.write_data[0];
            end
        end
        irq_status_next = (irq_kept | events.irq_event) & PIN_MASK;
        nmi_status_next = nmi_kept | events.nmi_event;
    end

    // Result: reads see status as it stood before this step.
    always_comb begin
        out_data_next.read_data = '0;
        if (in_data_reg.req_type == REQ_READ) begin
            if (in_data_reg.reg_sel == REG_SEL_IRQ) begin
                out_data_next.read_data = {9'd0, irq_status_reg};
            end else begin
                out_data_next.read_data =
                    {in_data_reg.nmi_pin_level, 15'd0, nmi_status_reg};
            end
        end
        out_data_next.irq_pending = irq_status_next;
        out_data_next.nmi_pending = nmi_status_next;
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            irq_sense_modes_reg <= IRQ_SENSE_RESET;
            nmi_sense_mode_reg  <= NMI_SENSE_FALLING;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_IRQ_SENSE: irq_sense_modes_reg <= cfg_wdata;
                CFG_NMI_SENSE: nmi_sense_mode_reg  <= cfg_wdata[0];
                default:       ;
            endcase
        end
    end

    // Sense state: commit only when the transaction moves to the result side.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            irq_status_reg      <= '0;
            nmi_status_reg      <= 1'b0;
            prev_irq_levels_reg <= '0;
            prev_nmi_level_reg  <= 1'b0;
            sample_primed_reg   <= 1'b0;
        end else if (advance) begin
            irq_status_reg      <= irq_status_next;
            nmi_status_reg      <= nmi_status_next;
            prev_irq_levels_reg <= in_data_reg.irq_pin_levels;
            prev_nmi_level_reg  <= in_data_reg.nmi_pin_level;
            sample_primed_reg   <= 1'b1;
        end
    end

    // Valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: hold while stalled
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule
